>>> sv/wpv_pkg.sv
package wpv_pkg;

    localparam int unsigned PosW = 33;
    localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

    localparam logic [31:0] IdRiff = 32'h46464952;
    localparam logic [31:0] IdWave = 32'h45564157;
    localparam logic [31:0] IdFmt  = 32'h20746D66;
    localparam logic [31:0] IdData = 32'h61746164;

    localparam logic [31:0] MaxRate     = 32'd384000;
    localparam logic [15:0] MaxChannels = 16'd32;

    localparam int unsigned DivBitsDefault = 32;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_TRUNC_HDR   = 4'd1,
        ST_BAD_CONT    = 4'd2,
        ST_UNSUPPORTED = 4'd3,
        ST_BAD_HDR     = 4'd4,
        ST_NO_FMT      = 4'd5,
        ST_NO_DATA     = 4'd6,
        ST_EMPTY_DATA  = 4'd7,
        ST_TRUNC_DATA  = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        PH_CONTAINER = 3'd0,
        PH_CHUNK_HDR = 3'd1,
        PH_BODY      = 3'd2,
        PH_PAD       = 3'd3,
        PH_DONE      = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CS_PARSE  = 3'd0,
        CS_CHECK  = 3'd1,
        CS_MULT   = 3'd2,
        CS_DIVIDE = 3'd3,
        CS_OUTPUT = 3'd4
    } t_ctrl_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] format_code;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_sec;
        logic [15:0] frame_bytes;
        logic [15:0] sample_bits;
        logic [32:0] pcm_start;
        logic [31:0] data_length;
        logic [31:0] num_frames;
    } t_out_beat;

    typedef struct packed {
        logic byte_en;
        logic check_en;
        logic mult_en;
        logic div_start;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic last_seen;
        logic div_done;
    } t_dp_status;

endpackage

>>> sv/wpv_divider.sv
module wpv_divider
    import wpv_pkg::*;
#(
    parameter int unsigned DivBits = DivBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_step,
    input  logic [DivBits-1:0] i_dividend,
    input  logic [15:0]        i_divisor,
    output logic [DivBits-1:0] o_quotient,
    output logic               o_done
);
    localparam int unsigned CntW = $clog2(DivBits + 1);
    localparam logic [CntW-1:0] CntInit = CntW'(DivBits);

    logic [DivBits-1:0] r_quot, n_quot;
    logic [15:0]        r_rem, n_rem;
    logic [15:0]        r_div;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic [16:0]        trial;
    logic [16:0]        diff;

    // restoring division, one quotient bit a cycle while i_step is high
    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        trial  = {r_rem, r_quot[DivBits-1]};
        diff   = trial - {1'b0, r_div};
        if (i_step && r_cnt != '0) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem  = diff[15:0];
                n_quot = {r_quot[DivBits-2:0], 1'b1};
            end else begin
                n_rem  = trial[15:0];
                n_quot = {r_quot[DivBits-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CntInit;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_quotient = r_quot;
    assign o_done     = (r_cnt == '0);
endmodule

>>> sv/wpv_datapath.sv
module wpv_datapath
    import wpv_pkg::*;
#(
    parameter int unsigned DivBits = DivBitsDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_beat   i_beat,
    output t_dp_status o_status,
    output t_out_beat  o_result
);
    logic [PosW-1:0] r_pos, r_cend, r_left, r_doff;
    logic [31:0]     r_word, r_rate, r_brate, r_dlen;
    t_phase          r_phase;
    t_kind           r_kind;
    logic            r_pad, r_err, r_hfmt, r_hdata, r_last;
    logic [3:0]      r_ferr;
    logic [15:0]     r_fmt, r_chan, r_align, r_bits;

    logic [PosW-1:0] n_pos, n_cend, n_left, n_doff;
    logic [31:0]     n_word, n_rate, n_brate, n_dlen;
    t_phase          n_phase;
    t_kind           n_kind;
    logic            n_pad, n_err, n_hfmt, n_hdata;
    logic [3:0]      n_ferr;
    logic [15:0]     n_fmt, n_chan, n_align, n_bits;

    logic [PosW-1:0] nxt, left_dec, kidx;
    logic [31:0]     shw;
    logic [PosW:0]   padded_w;

    // final check registers
    logic [3:0]  r_stat;
    logic        r_walked, r_need_mult;
    logic [15:0] r_eba;
    logic [47:0] r_prod;
    logic [3:0]  chk_stat;
    logic        chk_walked, chk_mult;
    logic [15:0] chk_eba;
    logic [15:0] bytes_per;
    logic [3:0]  fin_stat;
    logic [DivBits-1:0] quot;
    logic        div_done;

    function automatic void latch_err(input logic [3:0] code,
                                      inout logic err, inout logic [3:0] ferr,
                                      inout t_phase ph);
        if (!err) begin
            err  = 1'b1;
            ferr = code;
        end
        ph = PH_DONE;
    endfunction

    always_comb begin
        n_pos = r_pos; n_cend = r_cend; n_left = r_left; n_doff = r_doff;
        n_word = r_word; n_rate = r_rate; n_brate = r_brate; n_dlen = r_dlen;
        n_phase = r_phase; n_kind = r_kind; n_pad = r_pad; n_err = r_err;
        n_ferr = r_ferr; n_hfmt = r_hfmt; n_hdata = r_hdata;
        n_fmt = r_fmt; n_chan = r_chan; n_align = r_align; n_bits = r_bits;
        nxt      = (r_pos != PosMax) ? r_pos + 1'b1 : PosMax;
        shw      = {i_beat.data_byte, r_word[31:8]};
        left_dec = r_left - 1'b1;
        padded_w = {1'b0, nxt} + {2'b0, shw} + {{PosW{1'b0}}, shw[0]};
        kidx     = {1'b0, r_word} - r_left;
        case (r_phase)
            PH_CONTAINER: begin
                n_word = shw;
                if (r_pos == PosW'(3)) begin
                    if (shw != IdRiff) latch_err(ST_BAD_CONT, n_err, n_ferr, n_phase);
                end else if (r_pos == PosW'(7)) begin
                    n_cend = {1'b0, shw} + PosW'(8);
                end else if (r_pos == PosW'(11)) begin
                    if (shw != IdWave) begin
                        latch_err(ST_BAD_CONT, n_err, n_ferr, n_phase);
                    end else if (r_cend < PosW'(12)) begin
                        latch_err(ST_TRUNC_HDR, n_err, n_ferr, n_phase);
                    end else if (nxt >= r_cend) begin
                        n_phase = PH_DONE;
                    end else if (r_cend - nxt < PosW'(8)) begin
                        latch_err(ST_TRUNC_HDR, n_err, n_ferr, n_phase);
                    end else begin
                        n_phase = PH_CHUNK_HDR;
                        n_left  = PosW'(8);
                    end
                end
            end
            PH_CHUNK_HDR: begin
                n_word = shw;
                n_left = left_dec;
                if (left_dec == PosW'(4)) begin
                    n_kind = (shw == IdFmt) ? KIND_FMT :
                             (shw == IdData) ? KIND_DATA : KIND_OTHER;
                end else if (left_dec == '0) begin
                    if (padded_w > {1'b0, r_cend}) begin
                        latch_err((r_kind == KIND_DATA) ? ST_TRUNC_DATA : ST_TRUNC_HDR,
                                  n_err, n_ferr, n_phase);
                    end else if (r_kind == KIND_FMT && (r_hfmt || shw < 32'd16)) begin
                        latch_err(ST_BAD_HDR, n_err, n_ferr, n_phase);
                    end else if (r_kind == KIND_DATA && r_hdata) begin
                        latch_err(ST_BAD_HDR, n_err, n_ferr, n_phase);
                    end else if (r_kind == KIND_DATA && shw == '0) begin
                        latch_err(ST_EMPTY_DATA, n_err, n_ferr, n_phase);
                    end else begin
                        if (r_kind == KIND_FMT) n_hfmt = 1'b1;
                        if (r_kind == KIND_DATA) begin
                            n_hdata = 1'b1;
                            n_doff  = nxt;
                            n_dlen  = shw;
                        end
                        if (shw == '0) begin
                            if (nxt >= r_cend) begin
                                n_phase = PH_DONE;
                            end else if (r_cend - nxt < PosW'(8)) begin
                                latch_err(ST_TRUNC_HDR, n_err, n_ferr, n_phase);
                            end else begin
                                n_phase = PH_CHUNK_HDR;
                                n_left  = PosW'(8);
                            end
                        end else begin
                            n_phase = PH_BODY;
                            n_left  = {1'b0, shw};
                            n_pad   = shw[0];
                        end
                    end
                end
            end
            PH_BODY: begin
                if (r_kind == KIND_FMT && kidx < PosW'(16)) begin
                    case (kidx[3:0])
                        4'd0:  n_fmt[7:0]     = i_beat.data_byte;
                        4'd1:  n_fmt[15:8]    = i_beat.data_byte;
                        4'd2:  n_chan[7:0]    = i_beat.data_byte;
                        4'd3:  n_chan[15:8]   = i_beat.data_byte;
                        4'd4:  n_rate[7:0]    = i_beat.data_byte;
                        4'd5:  n_rate[15:8]   = i_beat.data_byte;
                        4'd6:  n_rate[23:16]  = i_beat.data_byte;
                        4'd7:  n_rate[31:24]  = i_beat.data_byte;
                        4'd8:  n_brate[7:0]   = i_beat.data_byte;
                        4'd9:  n_brate[15:8]  = i_beat.data_byte;
                        4'd10: n_brate[23:16] = i_beat.data_byte;
                        4'd11: n_brate[31:24] = i_beat.data_byte;
                        4'd12: n_align[7:0]   = i_beat.data_byte;
                        4'd13: n_align[15:8]  = i_beat.data_byte;
                        4'd14: n_bits[7:0]    = i_beat.data_byte;
                        default: n_bits[15:8] = i_beat.data_byte;
                    endcase
                end
                n_left = left_dec;
                if (left_dec == '0) begin
                    if (r_pad) begin
                        n_phase = PH_PAD;
                    end else if (nxt >= r_cend) begin
                        n_phase = PH_DONE;
                    end else if (r_cend - nxt < PosW'(8)) begin
                        latch_err(ST_TRUNC_HDR, n_err, n_ferr, n_phase);
                    end else begin
                        n_phase = PH_CHUNK_HDR;
                        n_left  = PosW'(8);
                    end
                end
            end
            PH_PAD: begin
                n_pad = 1'b0;
                if (nxt >= r_cend) begin
                    n_phase = PH_DONE;
                end else if (r_cend - nxt < PosW'(8)) begin
                    latch_err(ST_TRUNC_HDR, n_err, n_ferr, n_phase);
                end else begin
                    n_phase = PH_CHUNK_HDR;
                    n_left  = PosW'(8);
                end
            end
            default: begin
            end
        endcase
        n_pos = nxt;
    end

    // status priority, up to the consistency products
    always_comb begin
        chk_walked = 1'b0;
        chk_mult   = 1'b0;
        bytes_per  = {3'b0, r_bits[15:3]};
        chk_eba    = r_chan * bytes_per;
        if (r_pos < PosW'(12)) begin
            chk_stat = ST_TRUNC_HDR;
        end else if (r_err && r_ferr == ST_BAD_CONT) begin
            chk_stat = ST_BAD_CONT;
        end else if (r_cend < PosW'(12) || r_cend > r_pos) begin
            chk_stat = ST_TRUNC_HDR;
        end else begin
            chk_walked = 1'b1;
            if (r_err) chk_stat = r_ferr;
            else if (!r_hfmt) chk_stat = ST_NO_FMT;
            else if (!r_hdata) chk_stat = ST_NO_DATA;
            else if (r_fmt != 16'd1) chk_stat = ST_UNSUPPORTED;
            else if (r_chan == '0 || r_chan > MaxChannels || r_rate == '0 ||
                     r_rate > MaxRate ||
                     (r_bits != 16'd8 && r_bits != 16'd16 &&
                      r_bits != 16'd24 && r_bits != 16'd32))
                chk_stat = ST_UNSUPPORTED;
            else if (r_align != chk_eba) chk_stat = ST_BAD_HDR;
            else begin
                chk_stat = ST_OK;
                chk_mult = 1'b1;
            end
        end
    end

    wpv_divider #(.DivBits(DivBits)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend (DivBits'(r_dlen)),
        .i_divisor  (r_align),
        .o_quotient (quot),
        .o_done     (div_done)
    );

    always_comb begin
        fin_stat = r_stat;
        if (r_stat == ST_OK && r_need_mult) begin
            if ({16'b0, r_brate} != r_prod) fin_stat = ST_BAD_HDR;
            else if (32'(quot) * {16'b0, r_align} != r_dlen) fin_stat = ST_TRUNC_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_pos <= '0; r_cend <= '0; r_left <= '0; r_doff <= '0;
            r_word <= '0; r_rate <= '0; r_brate <= '0; r_dlen <= '0;
            r_phase <= PH_CONTAINER; r_kind <= KIND_OTHER; r_pad <= 1'b0;
            r_err <= 1'b0; r_ferr <= '0; r_hfmt <= 1'b0; r_hdata <= 1'b0;
            r_fmt <= '0; r_chan <= '0; r_align <= '0; r_bits <= '0;
            r_last <= 1'b0;
        end else if (i_cmd.byte_en) begin
            r_pos <= n_pos; r_cend <= n_cend; r_left <= n_left; r_doff <= n_doff;
            r_word <= n_word; r_rate <= n_rate; r_brate <= n_brate; r_dlen <= n_dlen;
            r_phase <= n_phase; r_kind <= n_kind; r_pad <= n_pad;
            r_err <= n_err; r_ferr <= n_ferr; r_hfmt <= n_hfmt; r_hdata <= n_hdata;
            r_fmt <= n_fmt; r_chan <= n_chan; r_align <= n_align; r_bits <= n_bits;
            r_last <= i_beat.last_byte;
        end
        if (i_cmd.check_en) begin
            r_stat      <= chk_stat;
            r_walked    <= chk_walked;
            r_need_mult <= chk_mult;
            r_eba       <= chk_eba;
        end
        if (i_cmd.mult_en) begin
            r_prod <= r_rate * r_eba;
        end
    end

    always_comb begin
        o_result = '0;
        o_result.status = fin_stat;
        if (r_walked) begin
            o_result.format_code   = r_fmt;
            o_result.channel_count = r_chan;
            o_result.rate_hz       = r_rate;
            o_result.bytes_per_sec = r_brate;
            o_result.frame_bytes   = r_align;
            o_result.sample_bits   = r_bits;
            if (fin_stat == ST_OK) begin
                o_result.pcm_start   = r_doff;
                o_result.data_length = r_dlen;
                o_result.num_frames  = 32'(quot);
            end
        end
    end

    assign o_status.last_seen = r_last;
    assign o_status.div_done  = div_done;
endmodule

>>> sv/wpv_ctrl.sv
module wpv_ctrl
    import wpv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);
    t_ctrl_state r_state, n_state;
    logic        accept;

    assign accept = (r_state == CS_PARSE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_PARSE:  if (i_status.last_seen) n_state = CS_CHECK;
            CS_CHECK:  n_state = CS_MULT;
            CS_MULT:   n_state = CS_DIVIDE;
            CS_DIVIDE: if (i_status.div_done) n_state = CS_OUTPUT;
            CS_OUTPUT: if (!i_out_stall) n_state = CS_PARSE;
            default:   n_state = CS_PARSE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            CS_PARSE: begin
                o_in_stall    = i_status.last_seen;
                o_cmd.byte_en = accept && !i_status.last_seen;
                o_cmd.check_en = i_status.last_seen;
            end
            CS_CHECK: begin
                o_cmd.mult_en   = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            CS_MULT:   o_cmd.div_step = 1'b1;
            CS_DIVIDE: o_cmd.div_step = 1'b1;
            CS_OUTPUT: begin
                o_out_valid  = 1'b1;
                o_cmd.finish = !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_PARSE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> sv/wav_pcm_header_validator_core.sv
// channel   dir  handshake               beat
// in        in   i_in_valid / o_in_stall  t_in_beat: data_byte, last_byte
// out       out  o_out_valid / i_out_stall t_out_beat: status .. num_frames
// one byte per cycle while parsing; after the last byte come the status check, the
// rate product and a restoring divide for the frame count, then the result beat
// the input stalls from the last byte until the result beat is taken
// synchronous active-low reset returns the parser to the container header
module wav_pcm_header_validator_core
    import wpv_pkg::*;
#(
    parameter int unsigned DivBits = DivBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);
    t_dp_cmd    cmd;
    t_dp_status status;

    wpv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    wpv_datapath #(.DivBits(DivBits)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_beat   (i_in_data),
        .o_status (status),
        .o_result (o_out_data)
    );
endmodule

>>> sv/wpv_checker.sv
module wpv_checker
    import wpv_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");

    a_no_in_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last_byte |=> o_in_stall)
        else $error("input open after last beat");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_TRUNC_DATA)
        else $error("status out of range");

    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.num_frames == '0)
        else $error("frame count on failure");
endmodule

bind wav_pcm_header_validator_core wpv_checker u_chk (.*);
